@@ hw/rtl/fik_pkg.sv @@
package fik_pkg;

    // chain size default
    localparam int FIK_SEGMENTS = 4;

    // field widths
    localparam int CW   = 24;           // coordinate
    localparam int DW   = 16;           // direction, Q2.14
    localparam int LW   = 18;           // segment length
    localparam int TW   = 16;           // tolerance
    localparam int NW   = 16;           // iteration count
    localparam int FRAC = 14;           // direction fraction bits

    // arithmetic unit widths
    localparam int VW   = 27;           // vector component
    localparam int PW   = 2 * VW;       // product and sum of squares
    localparam int MW   = VW;           // square root
    localparam int QW   = FRAC + 1;     // quotient of a normalized component
    localparam int DVW  = VW + FRAC + 1; // dividend of a normalized component
    localparam int CNW  = $clog2(MW);   // step counter

    // configuration port
    localparam int AW   = 5;
    localparam int PDW  = 32;

    localparam int DIR_ONE   = 16384;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // register reset values
    localparam int RST_ROOT_X  = 163840;
    localparam int RST_ROOT_Y  = 184320;
    localparam int RST_SEG_LEN = 32000;
    localparam int RST_TOL     = 1;
    localparam int RST_MAXIT   = 1024;

    localparam logic signed [VW-1:0] SAT_HI   = VW'(COORD_MAX);
    localparam logic signed [VW-1:0] SAT_LO   = VW'(COORD_MIN);
    localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (FRAC - 1);
    localparam logic [QW-1:0]        Q_ONE    = QW'(DIR_ONE);

    // register map
    typedef enum logic [2:0] {
        REG_ROOT_X   = 3'd0,
        REG_ROOT_Y   = 3'd1,
        REG_SEG_LEN  = 3'd2,
        REG_TOL      = 3'd3,
        REG_MAX_ITER = 3'd4
    } t_reg;

    // arithmetic unit operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQD,
        OP_NORM
    } t_mop;

    typedef enum logic [3:0] {
        M_IDLE,
        M_MUL,
        M_SQX,
        M_SQY,
        M_ADD,
        M_SQRT,
        M_DINIT,
        M_DIV,
        M_DONE
    } t_mstate;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T2,
        S_R2,
        S_D0,
        S_GN,
        S_GX,
        S_GY,
        S_BN,
        S_BX,
        S_BY,
        S_FOX,
        S_FOY,
        S_FN,
        S_FEX,
        S_FEY,
        S_CK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   start;
        t_mop                   op;
        logic signed [VW-1:0]   a;
        logic signed [VW-1:0]   b;
        logic signed [DW-1:0]   fbx;
        logic signed [DW-1:0]   fby;
    } t_math_cmd;

    typedef struct packed {
        logic                   done;
        logic signed [PW-1:0]   prod;
        logic [PW-1:0]          sum;
        logic signed [DW-1:0]   ux;
        logic signed [DW-1:0]   uy;
    } t_math_res;

    // (p + 2^13) >> 14 with floor
    function automatic logic signed [VW-1:0] fik_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + RND_HALF;
        return VW'(t >>> FRAC);
    endfunction

    // saturate to a 24-bit signed coordinate
    function automatic logic signed [CW-1:0] fik_sat(input logic signed [VW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI) begin
            r = CW'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = CW'(SAT_LO);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/fabrik_ik_solver.sv @@
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_target_x, i_target_y
// out       output     o_out_valid / i_out_ready  o_seg_index .. o_last
// cfg       input      psel, penable, pwrite      paddr, pwdata, prdata
//
// one target runs setup, a goal step when the target is out of reach, then
// the iterations used, then hands out one result per segment while the
// receiver keeps up; the shared multiply/square-root/divide unit does the
// work: two normalizes per segment per iteration (a zero vector keeps its
// fallback direction), plus six multiplies per segment and a distance check
// per iteration
// synchronous active-low reset returns the chain to a column below the root
// o_in_ready is high only between targets; results wait in the output register
module fabrik_ik_solver import fik_pkg::*; #(
    parameter int SEGMENTS = FIK_SEGMENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CW-1:0] i_target_x,
    input  logic signed [CW-1:0] i_target_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_seg_index,
    output logic signed [CW-1:0] o_joint_x,
    output logic signed [CW-1:0] o_joint_y,
    output logic signed [DW-1:0] o_dir_x,
    output logic signed [DW-1:0] o_dir_y,
    output logic                 o_converged,
    output logic [NW-1:0]        o_iterations_used,
    output logic                 o_last,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [PDW-1:0]       pwdata,
    output logic [PDW-1:0]       prdata,
    output logic                 pready
);

    localparam int IW = $clog2(SEGMENTS);
    localparam int RW = LW + $clog2(SEGMENTS);
    localparam logic [IW-1:0] TIP = IW'(SEGMENTS - 1);

    // configuration
    logic signed [CW-1:0] r_root_x, r_root_y;
    logic [LW-1:0]        r_seg_len;
    logic [TW-1:0]        r_tol;
    logic [NW-1:0]        r_max_iter;

    // chain store
    logic signed [CW-1:0] r_jx [SEGMENTS];
    logic signed [CW-1:0] r_jy [SEGMENTS];
    logic signed [DW-1:0] r_dx [SEGMENTS];
    logic signed [DW-1:0] r_dy [SEGMENTS];

    // sequencer state and working registers
    t_state               r_state, n_state;
    logic                 r_go, n_go;
    logic signed [CW-1:0] r_tx, r_ty, r_bx, r_by, r_ox, r_oy;
    logic signed [VW-1:0] r_gx, r_gy, r_sx;
    logic signed [DW-1:0] r_ux, r_uy;
    logic [PW-1:0]        r_tol2, r_reach2;
    logic [IW-1:0]        r_i;
    logic [NW-1:0]        r_iter;
    logic                 r_conv;

    // output register
    logic                 r_ovalid, r_olast, r_oconv;
    logic [1:0]           r_oseg;
    logic signed [CW-1:0] r_ojx, r_ojy;
    logic signed [DW-1:0] r_odx, r_ody;
    logic [NW-1:0]        r_oiter;

    t_math_cmd math_cmd;
    t_math_res math_res;

    fik_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (math_cmd),
        .o_res   (math_res)
    );

    // derived values
    logic [RW-1:0]        reach;
    logic [NW-1:0]        lim;
    logic                 at_limit, conv, far, in_acc, out_load, done;
    logic signed [VW-1:0] sc;
    logic signed [CW-1:0] rd_jx, rd_jy, bk_x, bk_y, fo_x, fo_y, fe_x, fe_y;
    logic signed [DW-1:0] rd_dx, rd_dy;

    assign reach    = RW'(r_seg_len) * RW'(SEGMENTS);
    assign lim      = (r_max_iter == '0) ? NW'(1) : r_max_iter;
    assign at_limit = r_iter >= lim;
    assign done     = math_res.done;
    assign sc       = fik_round(math_res.prod);
    assign conv     = math_res.sum <= r_tol2;
    assign far      = math_res.sum >= r_reach2;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    assign rd_jx = r_jx[r_i];
    assign rd_jy = r_jy[r_i];
    assign rd_dx = r_dx[r_i];
    assign rd_dy = r_dy[r_i];

    // backward joint, forward origin and forward end
    assign bk_x = fik_sat(VW'(r_bx) + r_sx);
    assign bk_y = fik_sat(VW'(r_by) + sc);
    assign fo_x = fik_sat(VW'(rd_jx) - sc);
    assign fo_y = fik_sat(VW'(rd_jy) - sc);
    assign fe_x = fik_sat(VW'(r_bx) - r_sx);
    assign fe_y = fik_sat(VW'(r_by) - sc);

    // next state and unit command
    always_comb begin
        n_state      = r_state;
        math_cmd     = '0;
        math_cmd.start = r_go;
        math_cmd.op  = OP_MUL;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_T2;
            end
            S_T2: begin
                math_cmd.a = VW'(r_tol);
                math_cmd.b = VW'(r_tol);
                if (done) n_state = S_R2;
            end
            S_R2: begin
                math_cmd.a = VW'(reach);
                math_cmd.b = VW'(reach);
                if (done) n_state = S_D0;
            end
            S_D0: begin
                math_cmd.op = OP_SQD;
                math_cmd.a  = VW'(r_tx) - VW'(r_root_x);
                math_cmd.b  = VW'(r_ty) - VW'(r_root_y);
                if (done) n_state = far ? S_GN : S_BN;
            end
            S_GN: begin
                math_cmd.op  = OP_NORM;
                math_cmd.a   = VW'(r_root_x) - VW'(r_tx);
                math_cmd.b   = VW'(r_root_y) - VW'(r_ty);
                math_cmd.fbx = '0;
                math_cmd.fby = DW'(DIR_ONE);
                if (done) n_state = S_GX;
            end
            S_GX: begin
                math_cmd.a = VW'(r_ux);
                math_cmd.b = VW'(reach);
                if (done) n_state = S_GY;
            end
            S_GY: begin
                math_cmd.a = VW'(r_uy);
                math_cmd.b = VW'(reach);
                if (done) n_state = S_BN;
            end
            S_BN: begin
                math_cmd.op  = OP_NORM;
                math_cmd.a   = VW'(rd_jx) - VW'(r_bx);
                math_cmd.b   = VW'(rd_jy) - VW'(r_by);
                math_cmd.fbx = rd_dx;
                math_cmd.fby = rd_dy;
                if (done) n_state = S_BX;
            end
            S_BX: begin
                math_cmd.a = VW'(r_ux);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = S_BY;
            end
            S_BY: begin
                math_cmd.a = VW'(r_uy);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = (r_i == '0) ? S_FOX : S_BN;
            end
            S_FOX: begin
                math_cmd.a = VW'(rd_dx);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = S_FOY;
            end
            S_FOY: begin
                math_cmd.a = VW'(rd_dy);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = S_FN;
            end
            S_FN: begin
                math_cmd.op  = OP_NORM;
                math_cmd.a   = VW'(r_bx) - VW'(r_ox);
                math_cmd.b   = VW'(r_by) - VW'(r_oy);
                math_cmd.fbx = rd_dx;
                math_cmd.fby = rd_dy;
                if (done) n_state = S_FEX;
            end
            S_FEX: begin
                math_cmd.a = VW'(r_ux);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = S_FEY;
            end
            S_FEY: begin
                math_cmd.a = VW'(r_uy);
                math_cmd.b = VW'(r_seg_len);
                if (done) n_state = (r_i == TIP) ? S_CK : S_FOX;
            end
            S_CK: begin
                math_cmd.op = OP_SQD;
                math_cmd.a  = r_gx - VW'(r_bx);
                math_cmd.b  = r_gy - VW'(r_by);
                if (done) n_state = (conv || at_limit) ? S_OUT : S_BN;
            end
            S_OUT: begin
                if (out_load && r_i == TIP) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_go = (n_state != r_state) && (n_state != S_IDLE) && (n_state != S_OUT);
    end

    // control, configuration and chain store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_go       <= 1'b0;
            r_ovalid   <= 1'b0;
            r_root_x   <= CW'(RST_ROOT_X);
            r_root_y   <= CW'(RST_ROOT_Y);
            r_seg_len  <= LW'(RST_SEG_LEN);
            r_tol      <= TW'(RST_TOL);
            r_max_iter <= NW'(RST_MAXIT);
            for (int k = 0; k < SEGMENTS; k++) begin
                r_jx[k] <= fik_sat(VW'(RST_ROOT_X));
                r_jy[k] <= fik_sat(VW'(RST_ROOT_Y - k * RST_SEG_LEN));
                r_dx[k] <= '0;
                r_dy[k] <= DW'(DIR_ONE);
            end
        end else begin
            r_state <= n_state;
            r_go    <= n_go;

            // register writes
            if (psel && penable && pwrite) begin
                unique case (t_reg'(paddr[AW-1:2]))
                    REG_ROOT_X:   r_root_x   <= pwdata[CW-1:0];
                    REG_ROOT_Y:   r_root_y   <= pwdata[CW-1:0];
                    REG_SEG_LEN:  r_seg_len  <= pwdata[LW-1:0];
                    REG_TOL:      r_tol      <= pwdata[TW-1:0];
                    REG_MAX_ITER: r_max_iter <= pwdata[NW-1:0];
                    default: begin
                    end
                endcase
            end

            // output register
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            // chain updates at the end of each segment step
            if (done && r_state == S_BY) begin
                r_jx[r_i] <= bk_x;
                r_jy[r_i] <= bk_y;
                r_dx[r_i] <= r_ux;
                r_dy[r_i] <= r_uy;
            end
            if (done && r_state == S_FEY) begin
                r_jx[r_i] <= r_bx;
                r_jy[r_i] <= r_by;
                r_dx[r_i] <= r_ux;
                r_dy[r_i] <= r_uy;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_tx <= i_target_x;
                    r_ty <= i_target_y;
                end
            end
            S_T2: if (done) r_tol2 <= $unsigned(math_res.prod);
            S_R2: if (done) r_reach2 <= $unsigned(math_res.prod);
            S_D0: begin
                if (done && !far) begin
                    r_gx   <= VW'(r_tx);
                    r_gy   <= VW'(r_ty);
                    r_i    <= TIP;
                    r_bx   <= r_tx;
                    r_by   <= r_ty;
                    r_iter <= NW'(1);
                end
            end
            S_GN, S_BN, S_FN: begin
                if (done) begin
                    r_ux <= math_res.ux;
                    r_uy <= math_res.uy;
                end
            end
            S_GX: if (done) r_gx <= VW'(r_root_x) - sc;
            S_GY: begin
                if (done) begin
                    r_gy   <= VW'(r_root_y) - sc;
                    r_i    <= TIP;
                    r_bx   <= r_tx;
                    r_by   <= r_ty;
                    r_iter <= NW'(1);
                end
            end
            S_BX, S_FEX: if (done) r_sx <= sc;
            S_BY: begin
                if (done) begin
                    if (r_i == '0) begin
                        r_bx <= r_root_x;
                        r_by <= r_root_y;
                    end else begin
                        r_bx <= bk_x;
                        r_by <= bk_y;
                        r_i  <= r_i - 1'b1;
                    end
                end
            end
            S_FOX: if (done) r_ox <= fo_x;
            S_FOY: if (done) r_oy <= fo_y;
            S_FEY: begin
                if (done) begin
                    r_bx <= fe_x;
                    r_by <= fe_y;
                    if (r_i != TIP) r_i <= r_i + 1'b1;
                end
            end
            S_CK: begin
                if (done) begin
                    r_conv <= conv;
                    if (conv || at_limit) begin
                        r_i <= '0;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                        r_i    <= TIP;
                        r_bx   <= r_tx;
                        r_by   <= r_ty;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_oseg  <= 2'(r_i);
                    r_ojx   <= rd_jx;
                    r_ojy   <= rd_jy;
                    r_odx   <= rd_dx;
                    r_ody   <= rd_dy;
                    r_oconv <= r_conv;
                    r_oiter <= r_iter;
                    r_olast <= (r_i == TIP);
                    if (r_i != TIP) r_i <= r_i + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[AW-1:2]))
            REG_ROOT_X:   prdata = PDW'($unsigned(r_root_x));
            REG_ROOT_Y:   prdata = PDW'($unsigned(r_root_y));
            REG_SEG_LEN:  prdata = PDW'(r_seg_len);
            REG_TOL:      prdata = PDW'(r_tol);
            REG_MAX_ITER: prdata = PDW'(r_max_iter);
            default:      prdata = '0;
        endcase
    end

    assign pready            = 1'b1;
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_seg_index       = r_oseg;
    assign o_joint_x         = r_ojx;
    assign o_joint_y         = r_ojy;
    assign o_dir_x           = r_odx;
    assign o_dir_y           = r_ody;
    assign o_converged       = r_oconv;
    assign o_iterations_used = r_oiter;
    assign o_last            = r_olast;

    // iteration count stays within the limit at each convergence check
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CK) |-> (r_iter != '0 && r_iter <= lim))
        else $error("iteration count out of range");

    // the final item always carries the tip segment index
    a_last_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last) |-> (o_seg_index == 2'(SEGMENTS - 1)))
        else $error("last flag on wrong segment");

    // unit finishes only while the sequencer waits on it
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_state != S_IDLE && r_state != S_OUT && !r_go))
        else $error("unexpected unit completion");

    // stored directions stay unit scaled
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (rd_dx <= DW'(DIR_ONE) && rd_dx >= -DW'(DIR_ONE)
                                && rd_dy <= DW'(DIR_ONE) && rd_dy >= -DW'(DIR_ONE)))
        else $error("direction out of range");

endmodule

@@ hw/rtl/fik_math.sv @@
module fik_math import fik_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_math_cmd i_cmd,
    output t_math_res o_res
);

    t_mstate r_st, n_st;
    t_mop    r_op;

    logic signed [VW-1:0] r_a, r_b;
    logic signed [DW-1:0] r_fbx, r_fby, r_ux, r_uy;
    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]        r_sum, r_rad;
    logic [MW-1:0]        r_root;
    logic [MW:0]          r_rem;
    logic [MW:0]          r_drem;
    logic [QW-1:0]        r_dlow, r_q;
    logic [CNW-1:0]       r_cnt;
    logic                 r_sel;

    // shared multiplier, operands picked by step
    logic signed [VW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    assign mul_x = (r_st == M_SQY) ? r_b : r_a;
    assign mul_y = (r_st == M_MUL || r_st == M_SQY) ? r_b : r_a;
    assign mul_p = PW'(mul_x) * PW'(mul_y);

    logic [PW-1:0] sum_next;
    assign sum_next = r_sum + $unsigned(r_prod);

    // square root, one result bit a step
    logic [MW+2:0] sq_sh, sq_trial, sq_diff;
    logic          sq_ge;
    assign sq_sh    = {r_rem, r_rad[PW-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    // component divide by magnitude, one quotient bit a step
    logic signed [VW-1:0] comp;
    logic [VW-1:0]        comp_abs;
    logic [DVW-1:0]       dvd;
    logic [MW+1:0]        dv_t, dv_diff;
    logic                 dv_ge;
    logic [QW-1:0]        q_next, q_clamp;
    logic signed [DW-1:0] dirv;

    assign comp     = r_sel ? r_b : r_a;
    assign comp_abs = comp[VW-1] ? VW'(-comp) : VW'(comp);
    assign dvd      = DVW'({comp_abs, {FRAC{1'b0}}}) + DVW'(r_root >> 1);
    assign dv_t     = {r_drem, r_dlow[QW-1]};
    assign dv_ge    = dv_t >= (MW+2)'(r_root);
    assign dv_diff  = dv_t - (MW+2)'(r_root);
    assign q_next   = {r_q[QW-2:0], dv_ge};
    assign q_clamp  = (q_next > Q_ONE) ? Q_ONE : q_next;
    assign dirv     = comp[VW-1] ? -$signed(DW'(q_clamp)) : $signed(DW'(q_clamp));

    // step sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            M_IDLE: begin
                if (i_cmd.start) begin
                    n_st = (i_cmd.op == OP_MUL) ? M_MUL : M_SQX;
                end
            end
            M_MUL:   n_st = M_DONE;
            M_SQX:   n_st = M_SQY;
            M_SQY:   n_st = M_ADD;
            M_ADD:   n_st = (r_op == OP_SQD) ? M_DONE : M_SQRT;
            M_SQRT: begin
                if (r_cnt == CNW'(MW - 1)) begin
                    n_st = M_DINIT;
                end
            end
            M_DINIT: n_st = (r_root == '0) ? M_DONE : M_DIV;
            M_DIV: begin
                if (r_cnt == CNW'(QW - 1)) begin
                    n_st = r_sel ? M_DONE : M_DINIT;
                end
            end
            M_DONE:  n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            M_IDLE: begin
                if (i_cmd.start) begin
                    r_op  <= i_cmd.op;
                    r_a   <= i_cmd.a;
                    r_b   <= i_cmd.b;
                    r_fbx <= i_cmd.fbx;
                    r_fby <= i_cmd.fby;
                    r_sel <= 1'b0;
                end
            end
            M_MUL, M_SQX: begin
                r_prod <= mul_p;
            end
            M_SQY: begin
                r_prod <= mul_p;
                r_sum  <= $unsigned(r_prod);
            end
            M_ADD: begin
                r_sum  <= sum_next;
                r_rad  <= sum_next;
                r_root <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            M_SQRT: begin
                r_rad  <= {r_rad[PW-3:0], 2'b00};
                r_rem  <= sq_ge ? sq_diff[MW:0] : sq_sh[MW:0];
                r_root <= {r_root[MW-2:0], sq_ge};
                r_cnt  <= r_cnt + 1'b1;
            end
            M_DINIT: begin
                if (r_root == '0) begin
                    // zero vector keeps the fallback direction
                    r_ux <= r_fbx;
                    r_uy <= r_fby;
                end else begin
                    r_drem <= (MW+1)'(dvd >> QW);
                    r_dlow <= dvd[QW-1:0];
                    r_q    <= '0;
                    r_cnt  <= '0;
                end
            end
            M_DIV: begin
                r_drem <= dv_ge ? dv_diff[MW:0] : dv_t[MW:0];
                r_dlow <= {r_dlow[QW-2:0], 1'b0};
                r_q    <= q_next;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNW'(QW - 1)) begin
                    if (r_sel) begin
                        r_uy <= dirv;
                    end else begin
                        r_ux  <= dirv;
                        r_sel <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.done = (r_st == M_DONE);
    assign o_res.prod = r_prod;
    assign o_res.sum  = r_sum;
    assign o_res.ux   = r_ux;
    assign o_res.uy   = r_uy;

endmodule
